>>> rtl/core/cle_pkg.sv
// package with shared types and codes for the circular list engine
`timescale 1ns / 1ps
`default_nettype none
package cle_pkg;

  typedef enum logic [2:0] {
    OP_INS_FRONT  = 3'd0,
    OP_INS_BACK   = 3'd1,
    OP_INS_BEFORE = 3'd2,
    OP_INS_AFTER  = 3'd3,
    OP_DEL_FRONT  = 3'd4,
    OP_DEL_BACK   = 3'd5,
    OP_DEL_KEY    = 3'd6,
    OP_READ_ALL   = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] data_value;
    logic signed [31:0] key_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] out_value;
    logic               last;
  } out_item_t;

  // datapath commands
  typedef enum logic [3:0] {
    DC_NONE,
    DC_LATCH,      // capture request, start walk at head (prev = tail)
    DC_READ,       // issue value/link read at cursor
    DC_STEP,       // advance cursor using read link
    DC_INS_FRONT,  // place new entry, becomes head
    DC_INS_BACK,   // place new entry, becomes tail
    DC_INS_BEFORE, // place new entry between prev and cursor
    DC_INS_AFTER,  // place new entry after cursor
    DC_DEL_FRONT,  // remove head
    DC_DEL_CUR,    // remove cursor (not head)
    DC_LINK_PREV   // update link of prev only (second write)
  } dcmd_t;

  typedef struct packed {
    dcmd_t cmd;
  } ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic one;
    logic match;     // value at cursor equals key (valid in walk)
    logic at_head;   // cursor is head
    logic at_tail;   // cursor is tail
    logic walk_last; // current is last entry in walk
  } stat_t;

endpackage
`default_nettype wire

>>> rtl/core/cle_ram.sv
// generic single write, single registered read ram
`timescale 1ns / 1ps
`default_nettype none
module cle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> rtl/core/cle_datapath.sv
// list store, pointers, free map and walk cursor
`timescale 1ns / 1ps
`default_nettype none
module cle_datapath #(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire cle_pkg::ctrl_t ctrl,
  input  wire cle_pkg::in_item_t req,
  output cle_pkg::stat_t      stat,
  output logic signed [31:0]  rd_value
);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [IW-1:0] head, tail, cur, prev, slot;
  logic [CW-1:0] count, walked;
  logic [CAPACITY-1:0] free_map;
  logic [VALUE_WIDTH-1:0] data_r, key_r;
  logic [VALUE_WIDTH-1:0] v_rdata;
  logic [IW-1:0] l_rdata, cur_link;

  logic v_we, l_we;
  logic [IW-1:0] v_waddr, l_waddr, l_wdata, l_raddr;

  // lowest free slot
  always_comb begin
    slot = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (free_map[i]) begin
        slot = IW'(i);
      end
    end
  end

  cle_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_vals (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(data_r),
    .raddr(cur), .rdata(v_rdata));

  cle_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_links (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(l_raddr), .rdata(l_rdata));

  assign l_raddr = cur;
  assign cur_link = l_rdata;

  // value and link writes; double writes are split with DC_LINK_PREV
  always_comb begin
    v_we = 1'b0;
    v_waddr = slot;
    l_we = 1'b0;
    l_waddr = slot;
    l_wdata = head;
    case (ctrl.cmd)
      cle_pkg::DC_INS_FRONT, cle_pkg::DC_INS_BACK: begin
        v_we = 1'b1;
        l_we = 1'b1;
        l_waddr = slot;
        l_wdata = (count == '0) ? slot : head;
      end
      cle_pkg::DC_INS_BEFORE: begin
        v_we = 1'b1;
        l_we = 1'b1;
        l_waddr = slot;
        l_wdata = cur;
      end
      cle_pkg::DC_INS_AFTER: begin
        v_we = 1'b1;
        l_we = 1'b1;
        l_waddr = slot;
        l_wdata = cur_link;
      end
      cle_pkg::DC_DEL_FRONT: begin
        l_we = (count != CW'(1));
        l_waddr = tail;
        l_wdata = cur_link;
      end
      cle_pkg::DC_DEL_CUR: begin
        l_we = 1'b1;
        l_waddr = prev;
        l_wdata = cur_link;
      end
      cle_pkg::DC_LINK_PREV: begin
        l_we = 1'b1;
        l_waddr = prev;
        l_wdata = cur;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      count <= '0;
      free_map <= '1;
      cur <= '0;
      prev <= '0;
      walked <= '0;
    end else begin
      case (ctrl.cmd)
        cle_pkg::DC_LATCH: begin
          cur <= head;
          prev <= tail;
          walked <= '0;
        end
        cle_pkg::DC_STEP: begin
          prev <= cur;
          cur <= cur_link;
          walked <= walked + CW'(1);
        end
        cle_pkg::DC_INS_FRONT, cle_pkg::DC_INS_BACK: begin
          free_map[slot] <= 1'b0;
          count <= count + CW'(1);
          if (count == '0) begin
            head <= slot;
            tail <= slot;
          end else begin
            // tail link to new entry
            prev <= tail;
            cur <= slot;
            if (ctrl.cmd == cle_pkg::DC_INS_FRONT) begin
              head <= slot;
            end else begin
              tail <= slot;
            end
          end
        end
        cle_pkg::DC_INS_BEFORE: begin
          free_map[slot] <= 1'b0;
          count <= count + CW'(1);
          cur <= slot;
        end
        cle_pkg::DC_INS_AFTER: begin
          free_map[slot] <= 1'b0;
          count <= count + CW'(1);
          if (cur == tail) begin
            tail <= slot;
          end
          prev <= cur;
          cur <= slot;
        end
        cle_pkg::DC_DEL_FRONT: begin
          free_map[head] <= 1'b1;
          count <= count - CW'(1);
          if (count == CW'(1)) begin
            head <= '0;
            tail <= '0;
          end else begin
            head <= cur_link;
          end
        end
        cle_pkg::DC_DEL_CUR: begin
          free_map[cur] <= 1'b1;
          count <= count - CW'(1);
          if (cur == tail) begin
            tail <= prev;
          end
        end
        default: ;
      endcase
      if (ctrl.cmd == cle_pkg::DC_LATCH) begin
        data_r <= VALUE_WIDTH'(req.data_value);
        key_r <= VALUE_WIDTH'(req.key_value);
      end
    end
  end

  // read-out value, sign extended or cut to 32 bits
  always_comb begin
    logic [63:0] ext;
    ext = 64'($signed(v_rdata));
    rd_value = ext[31:0];
  end

  assign stat.empty = (count == '0);
  assign stat.full = (count >= CW'(CAPACITY));
  assign stat.one = (count == CW'(1));
  assign stat.match = (v_rdata == key_r);
  assign stat.at_head = (cur == head);
  assign stat.at_tail = (cur == tail);
  assign stat.walk_last = (walked + CW'(1) == count);

`ifndef SYNTHESIS
  a_count_free: assert property (@(posedge clk) disable iff (rst)
    $countones(~free_map) == int'(count))
    else $error("free map disagrees with count");
  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> head == '0 && tail == '0)
    else $error("pointers not cleared on empty list");
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("count above capacity");
`endif
endmodule
`default_nettype wire

>>> rtl/core/cle_ctrl.sv
// request sequencer for the circular list engine
`timescale 1ns / 1ps
`default_nettype none
module cle_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire cle_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output cle_pkg::out_item_t     out_data,
  output cle_pkg::ctrl_t         ctrl,
  input  wire cle_pkg::stat_t    stat,
  input  wire logic signed [31:0] rd_value
);
  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_RD, S_WAIT, S_CHECK, S_FIX, S_EMIT, S_RD_OUT,
    S_WAIT_OUT, S_PUT_OUT, S_HOLD_OUT, S_DEL_RD, S_DEL_WAIT
  } state_t;

  state_t state;
  logic [2:0] op;
  logic accept;

  assign accept = in_valid && !in_stall;
  // a pending result holds off the next request
  assign in_stall = (state != S_IDLE) || out_valid;

  always_comb begin
    ctrl.cmd = cle_pkg::DC_NONE;
    case (state)
      S_IDLE: if (accept) ctrl.cmd = cle_pkg::DC_LATCH;
      S_DECIDE: begin
        case (cle_pkg::op_t'(op))
          cle_pkg::OP_INS_FRONT:
            if (!stat.full) ctrl.cmd = cle_pkg::DC_INS_FRONT;
          cle_pkg::OP_INS_BACK:
            if (!stat.full) ctrl.cmd = cle_pkg::DC_INS_BACK;
          default: ;
        endcase
      end
      S_CHECK: begin
        case (cle_pkg::op_t'(op))
          cle_pkg::OP_INS_BEFORE: if (stat.match) begin
            ctrl.cmd = stat.at_head ? cle_pkg::DC_INS_FRONT
                                    : cle_pkg::DC_INS_BEFORE;
          end else if (!stat.walk_last) ctrl.cmd = cle_pkg::DC_STEP;
          cle_pkg::OP_INS_AFTER: if (stat.match) ctrl.cmd = cle_pkg::DC_INS_AFTER;
            else if (!stat.walk_last) ctrl.cmd = cle_pkg::DC_STEP;
          cle_pkg::OP_DEL_KEY: if (stat.match) begin
            ctrl.cmd = stat.at_head ? cle_pkg::DC_DEL_FRONT : cle_pkg::DC_DEL_CUR;
          end else if (!stat.walk_last) ctrl.cmd = cle_pkg::DC_STEP;
          default: ;
        endcase
      end
      S_FIX: ctrl.cmd = cle_pkg::DC_LINK_PREV;
      S_DEL_WAIT: begin
        if (cle_pkg::op_t'(op) == cle_pkg::OP_DEL_FRONT || stat.one) begin
          ctrl.cmd = cle_pkg::DC_DEL_FRONT;
        end else if (stat.at_tail) begin
          ctrl.cmd = cle_pkg::DC_DEL_CUR;
        end else begin
          ctrl.cmd = cle_pkg::DC_STEP;
        end
      end
      S_WAIT_OUT: if (!out_valid || !out_stall) ctrl.cmd = cle_pkg::DC_STEP;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      op <= '0;
    end else begin
      if (out_valid && !out_stall && state != S_EMIT && state != S_WAIT_OUT)
        out_valid <= 1'b0;
      case (state)
        S_IDLE: if (accept) begin
          op <= in_data.operation;
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          out_data.out_value <= '0;
          out_data.last <= 1'b1;
          out_data.status <= cle_pkg::ST_OK;
          state <= S_EMIT;
          case (cle_pkg::op_t'(op))
            cle_pkg::OP_INS_FRONT, cle_pkg::OP_INS_BACK: begin
              if (stat.full) out_data.status <= cle_pkg::ST_FULL;
              else if (!stat.empty) state <= S_FIX;
            end
            cle_pkg::OP_INS_BEFORE, cle_pkg::OP_INS_AFTER: begin
              if (stat.empty) out_data.status <= cle_pkg::ST_EMPTY;
              else if (stat.full) out_data.status <= cle_pkg::ST_FULL;
              else state <= S_RD;
            end
            cle_pkg::OP_DEL_KEY: begin
              if (stat.empty) out_data.status <= cle_pkg::ST_EMPTY;
              else state <= S_RD;
            end
            cle_pkg::OP_DEL_FRONT, cle_pkg::OP_DEL_BACK: begin
              if (stat.empty) out_data.status <= cle_pkg::ST_EMPTY;
              else state <= S_DEL_RD;
            end
            default: begin
              if (stat.empty) out_data.status <= cle_pkg::ST_EMPTY;
              else state <= S_RD_OUT;
            end
          endcase
        end
        S_RD: state <= S_CHECK;
        S_CHECK: begin
          if (stat.match) begin
            if (cle_pkg::op_t'(op) == cle_pkg::OP_DEL_KEY) state <= S_EMIT;
            else if (cle_pkg::op_t'(op) == cle_pkg::OP_INS_BEFORE && stat.at_head)
              state <= S_FIX;
            else state <= S_FIX;
          end else if (stat.walk_last) begin
            out_data.status <= cle_pkg::ST_NOTFOUND;
            state <= S_EMIT;
          end else state <= S_RD;
        end
        S_FIX: state <= S_EMIT;
        S_DEL_RD: state <= S_DEL_WAIT;
        S_DEL_WAIT: begin
          if (cle_pkg::op_t'(op) == cle_pkg::OP_DEL_FRONT || stat.one
              || stat.at_tail) state <= S_EMIT;
          else state <= S_DEL_RD;
        end
        S_EMIT: if (!out_valid || !out_stall) begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        S_RD_OUT: state <= S_WAIT_OUT;
        S_WAIT_OUT: if (!out_valid || !out_stall) begin
          out_valid <= 1'b1;
          out_data.status <= cle_pkg::ST_OK;
          out_data.out_value <= rd_value;
          out_data.last <= stat.walk_last;
          state <= stat.walk_last ? S_HOLD_OUT : S_RD_OUT;
        end
        S_HOLD_OUT: if (!out_valid || !out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_DECIDE)
    else $error("accepted item did not start");
  a_out_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != cle_pkg::ST_OK |-> out_data.last)
    else $error("error result not final");
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE && !accept |-> ctrl.cmd == cle_pkg::DC_NONE)
    else $error("command issued while idle");
`endif
endmodule
`default_nettype wire

>>> rtl/core/circular_list_engine_core.sv
// top level of the circular list engine
//   channel | direction | payload
//   in      | input     | cle_pkg::in_item_t  (operation, data_value, key_value)
//   out     | output    | cle_pkg::out_item_t (status, out_value, last)
// one request at a time; simple ops need no walk, keyed ops and delete back
// walk the list entry by entry, and read all returns one entry per walk step,
// each step waiting on the registered read of the link memory in the loop
// rst is synchronous and clears pointers, count and free map at once
// out stall holds the result register, pauses the walk and holds off input
`timescale 1ns / 1ps
`default_nettype none
module circular_list_engine_core #(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire cle_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output cle_pkg::out_item_t      out_data
);
  cle_pkg::ctrl_t ctrl;
  cle_pkg::stat_t stat;
  logic signed [31:0] rd_value;

  cle_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data), .ctrl(ctrl), .stat(stat), .rd_value(rd_value));

  cle_datapath #(.CAPACITY(CAPACITY), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .ctrl(ctrl), .req(in_data), .stat(stat),
    .rd_value(rd_value));
endmodule
`default_nettype wire
